[rtl/u16u8_pkg.sv]
package u16u8_pkg;

    // utf-16 surrogate ranges (upper six bits of the code unit)
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // offset of the supplementary planes
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // utf-8 lead and continuation marks
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    // encoded length of one code point, stored as byte count minus one
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } len_t;

    // one queued job: an optional flushed high surrogate, then an optional code point
    typedef struct packed {
        logic        flush;
        logic [9:0]  held_bits;
        logic        main;
        logic [20:0] cp;
        logic        last;
    } job_t;

    // byte count of a code point
    function automatic len_t utf8_len(input logic [20:0] cp);
        len_t len;
        if (cp[20:16] != 5'd0) begin
            len = LEN_4;
        end
        else if (cp[15:11] != 5'd0) begin
            len = LEN_3;
        end
        else if (cp[10:7] != 4'd0) begin
            len = LEN_2;
        end
        else begin
            len = LEN_1;
        end
        return len;
    endfunction

    // byte number idx of the utf-8 encoding of cp
    function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input len_t len,
                                                input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: b = (idx == 2'd0) ? (LEAD_2 | {3'b000, cp[10:6]})
                                     : (CONT | {2'b00, cp[5:0]});
            LEN_3:
            begin
                unique case (idx)
                    2'd0:    b = LEAD_3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_4:
            begin
                unique case (idx)
                    2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/u16u8_front.sv]
module u16u8_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           code_unit,
    input  logic                  last_unit,
    input  logic                  unit_valid,
    output logic                  unit_ready,
    input  logic                  q_full,
    output logic                  q_push,
    output u16u8_pkg::job_t       q_job
);
    import u16u8_pkg::*;

    logic       held_reg, held_next;
    logic [9:0] held_bits_reg, held_bits_next;
    logic       is_high, is_low, fire;

    // classify the incoming unit
    assign is_high    = (code_unit[15:10] == HIGH_SURR_TAG);
    assign is_low     = (code_unit[15:10] == LOW_SURR_TAG);
    assign unit_ready = !q_full;
    assign fire       = unit_valid && unit_ready;

    // build the job for this unit
    always_comb
    begin
        q_job.flush     = held_reg && !is_low;
        q_job.held_bits = held_bits_reg;
        q_job.main      = !(is_high && !last_unit) || (held_reg && is_low);
        q_job.last      = last_unit;
        if (held_reg && is_low) begin
            q_job.cp = SUPP_BASE + {1'b0, held_bits_reg, code_unit[9:0]};
        end
        else begin
            q_job.cp = {5'd0, code_unit};
        end
        q_push = fire && (q_job.flush || q_job.main);
    end

    // surrogate hold update
    always_comb
    begin
        held_next      = held_reg;
        held_bits_next = held_bits_reg;
        if (fire) begin
            if (is_high && !last_unit && !held_reg) begin
                held_next      = 1'b1;
                held_bits_next = code_unit[9:0];
            end
            else if (is_high && !last_unit && held_reg) begin
                held_next      = 1'b1;
                held_bits_next = code_unit[9:0];
            end
            else begin
                held_next      = 1'b0;
                held_bits_next = 10'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg      <= 1'b0;
            held_bits_reg <= 10'd0;
        end
        else begin
            held_reg      <= held_next;
            held_bits_reg <= held_bits_next;
        end
    end

    // a non-final high surrogate is always held afterwards
    a_hold_set: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_high && !last_unit |=> held_reg)
        else $error("high surrogate not held");

    // nothing stays held past the end of a string
    a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_unit |=> !held_reg)
        else $error("surrogate held after final unit");

    // a transfer that pushes nothing must be a fresh hold
    a_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !q_push |-> is_high && !last_unit && !held_reg)
        else $error("unit dropped without output");

endmodule

[rtl/u16u8_queue.sv]
module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u16u8_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output u16u8_pkg::job_t  head_job
);
    import u16u8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign q_valid  = (count_reg != '0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // fill count tracks the pointer distance
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT &&
        (count_reg == FULL_CNT || count_reg == '0 || wr_ptr_reg != rd_ptr_reg))
        else $error("queue fill count inconsistent");

endmodule

[rtl/u16u8_back.sv]
module u16u8_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  u16u8_pkg::job_t  head_job,
    output logic             q_pop,
    output logic [7:0]       utf8_byte,
    output logic             last_byte,
    output logic             byte_valid,
    input  logic             byte_ready
);
    import u16u8_pkg::*;

    typedef enum logic {
        PH_FLUSH,
        PH_MAIN
    } phase_t;

    logic        busy_reg;
    job_t        job_reg;
    phase_t      phase_reg;
    logic [1:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [20:0] seg_cp;
    len_t        seg_len;
    logic        seg_end, job_end, emit;

    // current segment: flushed surrogate or main code point
    always_comb
    begin
        if (phase_reg == PH_FLUSH) begin
            seg_cp  = {5'd0, HIGH_SURR_TAG, job_reg.held_bits};
            seg_len = LEN_3;
        end
        else begin
            seg_cp  = job_reg.cp;
            seg_len = utf8_len(job_reg.cp);
        end
        seg_end = (idx_reg == 2'(seg_len));
        job_end = seg_end && (phase_reg == PH_MAIN || !job_reg.main);
        emit    = busy_reg && (!valid_reg || byte_ready);
        q_pop   = q_valid && (!busy_reg || (emit && job_end));
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_MAIN;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
            job_reg   <= '0;
            byte_reg  <= 8'd0;
            last_reg  <= 1'b0;
        end
        else begin
            if (q_pop) begin
                busy_reg  <= 1'b1;
                job_reg   <= head_job;
                phase_reg <= head_job.flush ? PH_FLUSH : PH_MAIN;
                idx_reg   <= 2'd0;
            end
            else if (emit) begin
                if (job_end) begin
                    busy_reg <= 1'b0;
                end
                else if (seg_end) begin
                    phase_reg <= PH_MAIN;
                    idx_reg   <= 2'd0;
                end
                else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            if (emit) begin
                valid_reg <= 1'b1;
                byte_reg  <= utf8_byte_at(seg_cp, seg_len, idx_reg);
                last_reg  <= job_reg.last && job_end;
            end
            else if (byte_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign utf8_byte  = byte_reg;
    assign last_byte  = last_reg;
    assign byte_valid = valid_reg;

    // flush phase only runs for jobs that carry a held surrogate
    a_flush_job: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && phase_reg == PH_FLUSH |-> job_reg.flush)
        else $error("flush phase without held surrogate");

    // end mark only on the final byte of a final job
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !(job_end && job_reg.last) |=> !last_reg)
        else $error("end mark on inner byte");

endmodule

[rtl/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder. Takes one 16-bit code unit per transfer (with a flag on the
// last unit of a string) and gives UTF-8 bytes, one per transfer, the last byte of the
// string flagged. A front stage classifies units and pairs surrogates, a queue of
// QUEUE_DEPTH jobs decouples it from a byte sequencer that drives a registered output.
// The output side sets the rate: one byte per cycle while the receiver is ready and jobs
// are queued, a unit giving as many bytes as it encodes to (1 to 3, 4 for a surrogate pair
// split over two units, up to 6 when an unpaired high surrogate is flushed, none for a held
// high surrogate). Units are accepted every cycle while the queue has room; the first byte
// of a unit passes through a queue slot, the sequencer's job register and the output register.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    input  logic        unit_valid,
    output logic        unit_ready,
    output logic [7:0]  utf8_byte,
    output logic        last_byte,
    output logic        byte_valid,
    input  logic        byte_ready
);
    import u16u8_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    job_t push_job, head_job;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head_job (head_job)
    );

    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head_job   (head_job),
        .q_pop      (q_pop),
        .utf8_byte  (utf8_byte),
        .last_byte  (last_byte),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready)
    );

endmodule
